/* rtl/rar_pkg.sv */
`default_nettype none
package rar_pkg;

    typedef enum logic [1:0] {
        FN_ADD = 2'd0,
        FN_SUB = 2'd1,
        FN_MUL = 2'd2,
        FN_DIV = 2'd3
    } t_func;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_A,
        OP_MUL_B,
        OP_MUL_D,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_DIVN_INIT,
        OP_DIV_STEP,
        OP_SAVE_NUM,
        OP_OUT_LOAD
    } t_dp_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_D,
        ST_CHECK,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_FIN
    } t_ctrl_state;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic num_zero;
        logic den_zero;
        logic gcd_done;
        logic div_done;
    } t_dp_sts;

endpackage
`default_nettype wire

/* rtl/rar_ctrl.sv */
`default_nettype none
module rar_ctrl
    import rar_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  wire     i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_ctrl_state r_state, n_state;
    logic        r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_in_ready = 1'b0;
        n_ovalid   = r_ovalid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                o_cmd.op = OP_MUL_A;
                n_state  = ST_MUL_B;
            end
            ST_MUL_B: begin
                o_cmd.op = OP_MUL_B;
                n_state  = ST_MUL_D;
            end
            ST_MUL_D: begin
                o_cmd.op = OP_MUL_D;
                n_state  = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_sts.den_zero || i_sts.num_zero) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.op = OP_GCD_INIT;
                    n_state  = ST_GCD;
                end
            end
            ST_GCD: begin
                if (i_sts.gcd_done) begin
                    o_cmd.op = OP_DIVN_INIT;
                    n_state  = ST_DIVN;
                end else begin
                    o_cmd.op = OP_GCD_STEP;
                end
            end
            ST_DIVN: begin
                if (i_sts.div_done) begin
                    // latch numerator quotient, start denominator division
                    o_cmd.op = OP_SAVE_NUM;
                    n_state  = ST_DIVD;
                end else begin
                    o_cmd.op = OP_DIV_STEP;
                end
            end
            ST_DIVD: begin
                if (i_sts.div_done) begin
                    n_state = ST_FIN;
                end else begin
                    o_cmd.op = OP_DIV_STEP;
                end
            end
            ST_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.op = OP_OUT_LOAD;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule
`default_nettype wire

/* rtl/rar_dp.sv */
`default_nettype none
module rar_dp
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire                            i_clk,
    input  t_dp_cmd                        i_cmd,
    output t_dp_sts                        o_sts,
    input  wire  [1:0]                     i_func,
    input  wire  signed [OPERAND_WIDTH-1:0] i_left_num,
    input  wire  signed [OPERAND_WIDTH-1:0] i_left_den,
    input  wire  signed [OPERAND_WIDTH-1:0] i_right_num,
    input  wire  signed [OPERAND_WIDTH-1:0] i_right_den,
    output logic signed [2*OPERAND_WIDTH:0]   o_out_num,
    output logic signed [2*OPERAND_WIDTH-1:0] o_out_den,
    output logic                           o_zero_den_error
);

    localparam int W  = OPERAND_WIDTH;
    localparam int P  = 2 * OPERAND_WIDTH;
    localparam int CW = $clog2(P + 1);

    t_func                r_func;
    logic signed [W-1:0]  r_ln, r_ld, r_rn, r_rd;
    logic signed [P:0]    r_acc;
    logic signed [P-1:0]  r_den;
    logic [P-1:0]         r_a, r_b, r_g, r_q, r_rem, r_qn;
    logic [CW-1:0]        r_k, r_cnt;

    logic signed [W-1:0]  mul_x, mul_y;
    logic signed [P-1:0]  prod;
    logic signed [P:0]    prod_ext;
    logic [P:0]           num_neg;
    logic [P-1:0]         num_mag, den_neg, den_mag, gcd_val;
    logic [P:0]           rem_sh, rem_diff;
    logic                 rem_ge;
    logic [P:0]           qn_ext;

    // operand select for the shared multiplier
    always_comb begin
        mul_x = r_ln;
        mul_y = r_rd;
        unique case (i_cmd.op)
            OP_MUL_A: begin
                mul_x = r_ln;
                mul_y = (r_func == FN_MUL) ? r_rn : r_rd;
            end
            OP_MUL_B: begin
                mul_x = r_rn;
                mul_y = r_ld;
            end
            OP_MUL_D: begin
                mul_x = r_ld;
                mul_y = (r_func == FN_DIV) ? r_rn : r_rd;
            end
            default: begin
                mul_x = r_ln;
                mul_y = r_rd;
            end
        endcase
    end

    assign prod     = mul_x * mul_y;
    assign prod_ext = {prod[P-1], prod};

    assign num_neg = -r_acc;
    assign num_mag = r_acc[P] ? num_neg[P-1:0] : r_acc[P-1:0];
    assign den_neg = -r_den;
    assign den_mag = r_den[P-1] ? den_neg : r_den;
    assign gcd_val = (r_a | r_b) << r_k;

    // restoring divider, one quotient bit per cycle
    assign rem_sh   = {r_rem, r_q[P-1]};
    assign rem_diff = rem_sh - {1'b0, r_g};
    assign rem_ge   = (rem_sh >= {1'b0, r_g});
    assign qn_ext   = {1'b0, r_qn};

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_func <= t_func'(i_func);
                r_ln   <= i_left_num;
                r_ld   <= i_left_den;
                r_rn   <= i_right_num;
                r_rd   <= i_right_den;
            end
            OP_MUL_A: r_acc <= prod_ext;
            OP_MUL_B: begin
                if (r_func == FN_ADD) begin
                    r_acc <= r_acc + prod_ext;
                end else if (r_func == FN_SUB) begin
                    r_acc <= r_acc - prod_ext;
                end
            end
            OP_MUL_D: r_den <= prod;
            OP_GCD_INIT: begin
                r_a <= num_mag;
                r_b <= den_mag;
                r_k <= '0;
            end
            OP_GCD_STEP: begin
                if (!r_a[0] && !r_b[0]) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (r_a >= r_b) begin
                    r_a <= r_a - r_b;
                end else begin
                    r_b <= r_b - r_a;
                end
            end
            OP_DIVN_INIT: begin
                r_g   <= gcd_val;
                r_q   <= num_mag;
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= rem_ge ? rem_diff[P-1:0] : rem_sh[P-1:0];
                r_q   <= {r_q[P-2:0], rem_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            OP_SAVE_NUM: begin
                r_qn  <= r_q;
                r_q   <= den_mag;
                r_rem <= '0;
                r_cnt <= '0;
            end
            OP_OUT_LOAD: begin
                if (o_sts.den_zero) begin
                    o_out_num        <= '0;
                    o_out_den        <= '0;
                    o_zero_den_error <= 1'b1;
                end else if (o_sts.num_zero) begin
                    o_out_num        <= '0;
                    o_out_den        <= {{(P-1){1'b0}}, 1'b1};
                    o_zero_den_error <= 1'b0;
                end else begin
                    o_out_num        <= r_acc[P] ? -qn_ext : qn_ext;
                    o_out_den        <= r_den[P-1] ? -r_q : r_q;
                    o_zero_den_error <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_sts.num_zero = (r_acc == '0);
        o_sts.den_zero = (r_den == '0);
        o_sts.gcd_done = (r_a == '0) || (r_b == '0);
        o_sts.div_done = (r_cnt == CW'(P));
    end

endmodule
`default_nettype wire

/* rtl/rational_arith_reduce_unit.sv */
// Rational arithmetic with reduction to lowest terms.
// Input stream: tuser = func (add, sub, mul, div); tdata = left_num, left_den,
// right_num, right_den, each OPERAND_WIDTH bits, lowest first.
// Output stream: tdata = out_num (2W+1 bits) then out_den (2W bits);
// tuser = zero_den_error. A zero denominator gives 0/0 with the error flag,
// a zero numerator gives 0/1; otherwise both parts are divided by the gcd
// of their magnitudes and keep their own signs.
// One word is processed at a time. The zero cases go straight from the
// products to the output; otherwise a binary gcd and two divisions follow.
// A single multiplier forms the three products, the gcd loop runs one
// shift or subtract per cycle, and a shared restoring divider yields one
// quotient bit per cycle.
// The result sits in an output register, so a finished word is held while
// the receiver stalls and the next word is accepted meanwhile; the unit then
// waits at completion until the register frees.
// Reset (synchronous, active low) empties the output and returns to idle.
`default_nettype none
module rational_arith_reduce_unit
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // left_num, left_den, right_num, right_den
    input  wire  [((4*OPERAND_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // func
    input  wire  [1:0]                         i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire                                i_m_axis_tready,
    // out_num, out_den, zero padding
    output logic [((4*OPERAND_WIDTH+8)/8)*8-1:0] o_m_axis_tdata,
    // zero_den_error
    output logic                               o_m_axis_tuser
);

    localparam int W  = OPERAND_WIDTH;
    localparam int P  = 2 * OPERAND_WIDTH;
    localparam int OW = ((4*OPERAND_WIDTH+8)/8)*8;

    t_dp_cmd            cmd;
    t_dp_sts            sts;
    logic signed [P:0]   out_num;
    logic signed [P-1:0] out_den;
    logic                out_err;

    rar_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    rar_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_func           (i_s_axis_tuser),
        .i_left_num       (i_s_axis_tdata[W-1:0]),
        .i_left_den       (i_s_axis_tdata[2*W-1:W]),
        .i_right_num      (i_s_axis_tdata[3*W-1:2*W]),
        .i_right_den      (i_s_axis_tdata[4*W-1:3*W]),
        .o_out_num        (out_num),
        .o_out_den        (out_den),
        .o_zero_den_error (out_err)
    );

    assign o_m_axis_tdata = {{(OW-2*P-1){1'b0}}, out_den, out_num};
    assign o_m_axis_tuser = out_err;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted while busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> (out_num == '0) && (out_den == '0))
        else $error("error word with nonzero fraction");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |-> (out_den != '0))
        else $error("zero denominator without error flag");
`endif

endmodule
`default_nettype wire

/* test/tb_rational_arith_reduce_unit.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_rational_arith_reduce_unit;
    import rar_pkg::*;

    localparam int W   = 16;
    localparam int IDW = ((4*W+7)/8)*8;
    localparam int ODW = ((4*W+8)/8)*8;
    localparam int NW  = 2*W+1;
    localparam int DW  = 2*W;
    localparam int N_RANDOM = 1330;

    typedef struct packed {
        t_func           fn;
        logic [W-1:0]    ln, ld, rn, rd;
    } t_frac_op;

    typedef struct packed {
        logic [NW-1:0]   num;
        logic [DW-1:0]   den;
        logic            err;
    } t_frac_res;

    logic             i_clk, i_rst_n;
    logic             i_s_axis_tvalid, i_m_axis_tready;
    logic [IDW-1:0]   i_s_axis_tdata;
    logic [1:0]       i_s_axis_tuser;
    logic             o_s_axis_tready, o_m_axis_tvalid, o_m_axis_tuser;
    logic [ODW-1:0]   o_m_axis_tdata;

    rational_arith_reduce_unit #(.OPERAND_WIDTH(W)) dut (.*);

    t_frac_op  op_queue[$];
    t_frac_res reduced_queue[$];
    int        n_mismatch = 0;
    bit        stim_done = 0;
    bit        hold_send = 0;
    int        send_wait = 0, recv_wait = 0;
    // handshakes seen at the last rising edge
    bit        in_acc = 0, out_acc = 0;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_frac_res reduce_frac(t_frac_op p);
        longint ln, ld, rn, rd, num, den;
        longint unsigned g, qn, qd;
        t_frac_res r;
        ln = longint'($signed(p.ln));
        ld = longint'($signed(p.ld));
        rn = longint'($signed(p.rn));
        rd = longint'($signed(p.rd));
        case (p.fn)
            FN_ADD: begin num = ln*rd + rn*ld; den = ld*rd; end
            FN_SUB: begin num = ln*rd - rn*ld; den = ld*rd; end
            FN_MUL: begin num = ln*rn;         den = ld*rd; end
            default: begin num = ln*rd;        den = ld*rn; end
        endcase
        r = '0;
        if (den == 0) begin
            r.err = 1'b1;
        end else if (num == 0) begin
            r.den = DW'(1);
        end else begin
            qn = num < 0 ? -num : num;
            qd = den < 0 ? -den : den;
            g = gcd_of(qn, qd);
            qn = qn / g;
            qd = qd / g;
            r.num = num < 0 ? NW'(-qn) : NW'(qn);
            r.den = den < 0 ? DW'(-qd) : DW'(qd);
        end
        return r;
    endfunction

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(W-1){1'b0}}};
            1: return {1'b0, {(W-1){1'b1}}};
            2: return '0;
            3: return W'($urandom_range(0, 12)) - W'(6);
            4, 5: return W'($urandom_range(0, 200)) - W'(100);
            default: return W'($urandom);
        endcase
    endfunction

    // driver: new word after a random gap, change on falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            i_s_axis_tuser  <= '0;
        end else if (in_acc) begin
            // accepted at the previous rising edge; prediction done in monitor
            i_s_axis_tvalid <= 1'b0;
            send_wait <= $urandom_range(0, 9);
        end else if (!i_s_axis_tvalid && !hold_send && op_queue.size() > 0) begin
            if (send_wait > 0) begin
                send_wait <= send_wait - 1;
            end else begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser  <= op_queue[0].fn;
                i_s_axis_tdata  <= {op_queue[0].rd, op_queue[0].rn,
                                    op_queue[0].ld, op_queue[0].ln};
            end
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (out_acc) begin
            i_m_axis_tready <= 1'b0;
            recv_wait <= $urandom_range(0, 9);
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // monitor: predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        t_frac_res got, want;
        in_acc  <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        out_acc <= i_rst_n && o_m_axis_tvalid && i_m_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            reduced_queue.push_back(reduce_frac(op_queue.pop_front()));
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.num = o_m_axis_tdata[NW-1:0];
            got.den = o_m_axis_tdata[NW+DW-1:NW];
            got.err = o_m_axis_tuser;
            if (reduced_queue.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected word: num=%0d den=%0d err=%0b",
                             $signed(got.num), $signed(got.den), got.err);
            end else begin
                want = reduced_queue.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp %0d/%0d err=%0b, got %0d/%0d err=%0b",
                                 $signed(want.num), $signed(want.den), want.err,
                                 $signed(got.num), $signed(got.den), got.err);
                end
            end
        end
    end

    task automatic queue_op(t_func fn, int ln, ld, rn, rd);
        op_queue.push_back('{fn, W'(ln), W'(ld), W'(rn), W'(rd)});
    endtask

    initial begin
        t_frac_op p;
        logic [W-1:0] mn, mx;
        mn = {1'b1, {(W-1){1'b0}}};
        mx = {1'b0, {(W-1){1'b1}}};
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed corners
        queue_op(FN_ADD, 1, 2, 1, 3);
        queue_op(FN_SUB, 1, 2, 1, 2);              // zero numerator
        queue_op(FN_MUL, 3, 0, 5, 7);              // zero denominator
        queue_op(FN_DIV, 3, 4, 0, 5);              // divide by zero fraction
        queue_op(FN_ADD, 0, 0, 0, 0);              // zero over zero
        queue_op(FN_MUL, -4, -6, 2, 3);            // both negative
        queue_op(FN_DIV, -6, 5, 4, -10);
        queue_op(FN_ADD, $signed(mn), $signed(mn), $signed(mn), $signed(mn));
        queue_op(FN_SUB, $signed(mn), $signed(mx), $signed(mx), $signed(mn));
        queue_op(FN_MUL, $signed(mx), $signed(mx), $signed(mx), $signed(mx));
        queue_op(FN_DIV, $signed(mn), $signed(mx), $signed(mn), $signed(mx));
        queue_op(FN_ADD, $signed(mx), 1, $signed(mx), 1);
        queue_op(FN_SUB, $signed(mn), 1, $signed(mx), 1);
        queue_op(FN_MUL, $signed(mn), 1, $signed(mn), 1);
        queue_op(FN_DIV, $signed(mn), 1, 1, $signed(mn));
        queue_op(FN_ADD, -1, -1, -1, -1);
        queue_op(FN_SUB, 7, -3, -7, 3);
        queue_op(FN_DIV, 12, -18, -8, 6);
        wait (op_queue.size() == 0);

        // hold-off: drain everything before the random part
        hold_send = 1;
        wait (reduced_queue.size() == 0);
        repeat (20) @(posedge i_clk);
        hold_send = 0;

        for (int i = 0; i < N_RANDOM; i++) begin
            p.fn = t_func'($urandom_range(0, 3));
            p.ln = pick_operand();
            p.ld = pick_operand();
            p.rn = pick_operand();
            p.rd = pick_operand();
            op_queue.push_back(p);
        end
        wait (op_queue.size() == 0);
        wait (reduced_queue.size() == 0);
        repeat (300) @(posedge i_clk);
        if (n_mismatch == 0 && reduced_queue.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

/* files.f */
rtl/rar_pkg.sv
rtl/rar_ctrl.sv
rtl/rar_dp.sv
rtl/rational_arith_reduce_unit.sv
test/tb_rational_arith_reduce_unit.sv
